FILE: rtl/pdce_pkg.sv
`default_nettype none
package pdce_pkg;

  localparam int MaxOwnersDef  = 8;
  localparam int LocalPagesDef = 256;
  localparam int TotalPagesDef = 2048;
  localparam int TagCountDef   = 256;

  localparam int PageW = 11;
  localparam int NodeW = 3;
  localparam int TagW  = 8;

  typedef enum logic [2:0] {
    K_SEND    = 3'd0,
    K_SETPERM = 3'd1,
    K_FETCH   = 3'd2,
    K_LOCAL   = 3'd3,
    K_DONE    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    NS_INVALID   = 2'd0,
    NS_READING   = 2'd1,
    NS_MODIFYING = 2'd2
  } nstate_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_WRONG    = 2'd1,
    ST_INCONSIS = 2'd2
  } status_e;

  localparam logic [1:0] PermNone = 2'd0;
  localparam logic [1:0] PermRd   = 2'd1;
  localparam logic [1:0] PermRw   = 2'd2;

  localparam logic [0:0] RegNodeId = 1'b0;
  localparam logic [0:0] RegOwnCnt = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic       latch;     // capture request, start division
    logic       div_step;  // one restoring-division step
    logic       rd_mem;    // issue directory read
    logic       cap_ent;   // capture directory entry
    logic       scan_clr;  // reset scan index
    logic       scan_inc;  // advance scan index
    logic       inv_scan;  // invalidate node at scan index
    logic       wr_mem;    // write working entry back
    logic       emit;      // load output register
    kind_e      kind;
    logic [1:0] dsel;      // 0 req, 1 scan, 2 modifier, 3 node_id
    logic [1:0] perm;
    logic       reply;
    logic [1:0] status;
    logic       last;
    logic [2:0] upd;       // entry update op
  } cmd_t;

  localparam logic [2:0] UpdNone   = 3'd0;
  localparam logic [2:0] UpdRdClean = 3'd1;
  localparam logic [2:0] UpdRdMod  = 3'd2;
  localparam logic [2:0] UpdWrClean = 3'd3;
  localparam logic [2:0] UpdWrMod  = 3'd4;

  // datapath -> controller status
  typedef struct packed {
    logic div_done;
    logic wrong_home;
    logic req_bad;
    logic modified;
    logic mod_bad;
    logic req_local;
    logic mod_local;
    logic local_not_rd;
    logic req_rd;
    logic func;
    logic scan_end;
    logic scan_hit;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/pdce_ram.sv
`default_nettype none
module pdce_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/pdce_datapath.sv
`default_nettype none
module pdce_datapath import pdce_pkg::*; #(
  parameter int MaxOwners  = MaxOwnersDef,
  parameter int LocalPages = LocalPagesDef,
  parameter int TotalPages = TotalPagesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o,
  input  wire logic [NodeW-1:0] node_id_i,
  input  wire logic [3:0]       owner_count_i,
  input  wire logic             func_i,
  input  wire logic [NodeW-1:0] requester_i,
  input  wire logic [PageW-1:0] page_i,
  input  wire logic [TagW-1:0]  tag_i,
  input  wire logic             tag_valid_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [2:0]       msg_kind_o,
  output logic      [NodeW-1:0] dest_o,
  output logic      [PageW-1:0] page_out_o,
  output logic      [1:0]       perm_o,
  output logic                  is_reply_o,
  output logic      [TagW-1:0]  reply_tag_o,
  output logic      [1:0]       status_o,
  output logic                  last_o
);
  localparam int IdxW  = $clog2(LocalPages);
  localparam int SlotW = $clog2(MaxOwners);
  localparam int NodeFW = 2 * MaxOwners;
  localparam int EntW  = 1 + SlotW + NodeFW;
  localparam logic [4:0] MaxCnt = 5'(MaxOwners);

  logic             func_q;
  logic [NodeW-1:0] req_q;
  logic [PageW-1:0] page_q;
  logic [TagW-1:0]  tag_q;
  logic             tv_q;
  logic [3:0]       cnt_q;
  logic [PageW-1:0] quo_q, rem_q, dvd_q;
  logic [3:0]       dstep_q;
  logic [SlotW:0]   scan_q;
  logic             mod_q;
  logic [SlotW-1:0] modr_q;
  logic [1:0]       ns_q [MaxOwners];

  logic [3:0] cnt_eff;
  always_comb begin
    cnt_eff = (owner_count_i == 4'd0) ? 4'd1 : owner_count_i;
    if ({1'b0, cnt_eff} > MaxCnt) cnt_eff = MaxCnt[3:0];
  end

  // restoring division page / cnt, one bit per cycle while the output is not stalled
  logic [PageW:0] trial;
  assign trial = {rem_q, dvd_q[PageW-1]} - {{(PageW-3){1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i; req_q <= requester_i; page_q <= page_i;
      tag_q <= tag_i; tv_q <= tag_valid_i; cnt_q <= cnt_eff;
      quo_q <= '0; rem_q <= '0; dvd_q <= page_i;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (!trial[PageW]) begin
        rem_q <= trial[PageW-1:0];
        quo_q <= {quo_q[PageW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[PageW-2:0], dvd_q[PageW-1]};
        quo_q <= {quo_q[PageW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dstep_q <= '0;
    else if (cmd_i.latch) dstep_q <= '0;
    else if (cmd_i.div_step) dstep_q <= dstep_q + 4'd1;
  end

  // directory with valid bits: unwritten entry reads as reset value
  logic [LocalPages-1:0] vld_q;
  logic [EntW-1:0] rdata, wdata;
  logic            rd_vld_q;
  logic [IdxW-1:0] idx;
  assign idx = IdxW'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_mem) vld_q[idx] <= 1'b1;
      if (cmd_i.rd_mem) rd_vld_q <= vld_q[idx];
    end
  end

  always_comb begin
    wdata = '0;
    wdata[EntW-1] = mod_q;
    wdata[NodeFW +: SlotW] = modr_q;
    for (int k = 0; k < MaxOwners; k++) wdata[2*k +: 2] = ns_q[k];
  end

  pdce_ram #(.Width(EntW), .Depth(LocalPages)) u_dir (
    .clk_i(clk_i), .we_i(cmd_i.wr_mem), .waddr_i(idx), .wdata_i(wdata),
    .re_i(cmd_i.rd_mem), .raddr_i(idx), .rdata_o(rdata)
  );

  logic [SlotW-1:0] rq_s, nid_s, sc_s;
  assign rq_s  = SlotW'(req_q);
  assign nid_s = SlotW'(node_id_i);
  assign sc_s  = scan_q[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_ent) begin
      mod_q  <= rd_vld_q ? rdata[EntW-1] : 1'b0;
      modr_q <= rd_vld_q ? rdata[NodeFW +: SlotW] : '0;
      for (int k = 0; k < MaxOwners; k++)
        ns_q[k] <= rd_vld_q ? rdata[2*k +: 2] : NS_READING;
    end else begin
      if (cmd_i.inv_scan) ns_q[sc_s] <= NS_INVALID;
      unique case (cmd_i.upd)
        UpdRdClean: ns_q[rq_s] <= NS_READING;
        UpdRdMod: begin
          if (modr_q != nid_s) ns_q[nid_s] <= NS_READING;
          ns_q[modr_q] <= NS_READING;
          if (rq_s != nid_s) ns_q[rq_s] <= NS_READING;
          mod_q <= 1'b0; modr_q <= '0;
        end
        UpdWrClean: begin
          if (rq_s != nid_s) ns_q[nid_s] <= NS_INVALID;
          ns_q[rq_s] <= NS_MODIFYING;
          mod_q <= 1'b1; modr_q <= rq_s;
        end
        UpdWrMod: begin
          ns_q[modr_q] <= NS_INVALID;
          ns_q[rq_s] <= NS_MODIFYING;
          modr_q <= rq_s;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_q <= '0;
    else if (cmd_i.scan_clr) scan_q <= '0;
    else if (cmd_i.scan_inc) scan_q <= scan_q + 1'b1;
  end

  // output register
  logic [NodeW-1:0] dsel_v;
  always_comb begin
    unique case (cmd_i.dsel)
      2'd0: dsel_v = req_q;
      2'd1: dsel_v = NodeW'(scan_q);
      2'd2: dsel_v = NodeW'(modr_q);
      default: dsel_v = node_id_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      msg_kind_o  <= cmd_i.kind;
      dest_o      <= dsel_v;
      page_out_o  <= page_q;
      perm_o      <= cmd_i.perm;
      is_reply_o  <= cmd_i.reply;
      reply_tag_o <= cmd_i.reply ? tag_q : '0;
      status_o    <= cmd_i.status;
      last_o      <= cmd_i.last;
    end
  end

  always_comb begin
    stat_o.div_done   = (dstep_q == 4'(PageW));
    stat_o.wrong_home = ({5'd0, page_q} >= 16'(TotalPages)) || (rem_q != {8'd0, node_id_i});
    stat_o.req_bad    = ({1'b0, req_q} >= cnt_q) || (req_q != node_id_i && !tv_q);
    stat_o.modified   = mod_q;
    stat_o.mod_bad    = mod_q && ((4'(modr_q) >= cnt_q) || modr_q == rq_s);
    stat_o.req_local  = (req_q == node_id_i);
    stat_o.mod_local  = (modr_q == nid_s);
    stat_o.local_not_rd = (ns_q[nid_s] != NS_READING);
    stat_o.req_rd     = (ns_q[rq_s] == NS_READING);
    stat_o.func       = func_q;
    stat_o.scan_end   = (5'(scan_q) >= 5'(cnt_q));
    stat_o.scan_hit   = (sc_s != rq_s) && (sc_s != nid_s) && (ns_q[sc_s] == NS_READING);
    stat_o.out_busy   = out_valid_o && out_stall_i;
  end

`ifndef NO_ASSERTIONS
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstep_q <= 4'(PageW)) else $error("division overran");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_o && out_stall_i)) else $error("output overwritten");
  a_wr_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_mem && mod_q |-> ns_q[modr_q] == NS_MODIFYING)
    else $error("modifier not modifying");
`endif
endmodule
`default_nettype wire

FILE: rtl/pdce_ctrl.sv
`default_nettype none
module pdce_ctrl import pdce_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CHK, S_RD, S_CAP, S_DECIDE, S_SCAN, S_GRANT,
    S_LOCAL, S_SEND2, S_WB, S_DONE
  } state_e;

  state_e    state_q;
  logic [1:0] st_q;
  logic      go;

  // latch on acceptance
  assign in_stall_o = (state_q != S_IDLE);
  assign go = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.kind = K_DONE;
    cmd_o.upd = UpdNone;
    cmd_o.latch = go;
    if (!stat_i.out_busy) begin
      unique case (state_q)
        S_DIV: cmd_o.div_step = !stat_i.div_done;
        S_RD:  cmd_o.rd_mem = 1'b1;
        S_CAP: begin cmd_o.cap_ent = 1'b1; cmd_o.scan_clr = 1'b1; end
        S_DECIDE: begin
          if (stat_i.mod_bad) ;
          else if (!stat_i.func && !stat_i.modified) begin
            if (!stat_i.req_local) begin
              cmd_o.emit = 1'b1; cmd_o.kind = K_SEND; cmd_o.perm = PermRd;
              cmd_o.reply = 1'b1; cmd_o.upd = UpdRdClean;
            end
          end else if (!stat_i.func) begin
            // modified page read back to readable: entry updated here
            cmd_o.upd = UpdRdMod;
            if (!stat_i.mod_local) begin
              cmd_o.emit = 1'b1; cmd_o.kind = K_FETCH; cmd_o.dsel = 2'd2;
              cmd_o.perm = PermRd;
            end
          end else if (stat_i.modified) begin
            if (!stat_i.mod_local) begin
              cmd_o.emit = 1'b1; cmd_o.kind = K_FETCH; cmd_o.dsel = 2'd2;
              cmd_o.perm = PermNone;
            end
          end
        end
        S_SCAN: begin
          if (!stat_i.scan_end) begin
            cmd_o.scan_inc = 1'b1;
            if (stat_i.scan_hit) begin
              cmd_o.emit = 1'b1; cmd_o.kind = K_SETPERM; cmd_o.dsel = 2'd1;
              cmd_o.inv_scan = 1'b1;
            end
          end
        end
        S_GRANT: begin
          // grant kind is picked from the entry before the write update lands
          cmd_o.emit = 1'b1;
          cmd_o.upd = stat_i.modified ? UpdWrMod : UpdWrClean;
          if (stat_i.req_local) begin
            cmd_o.kind = K_LOCAL; cmd_o.dsel = 2'd3; cmd_o.perm = PermRw;
          end else begin
            cmd_o.kind = (!stat_i.modified && stat_i.req_rd) ? K_SETPERM : K_SEND;
            cmd_o.perm = PermRw; cmd_o.reply = 1'b1;
          end
        end
        S_SEND2: begin
          cmd_o.emit = 1'b1; cmd_o.kind = K_SEND; cmd_o.perm = PermRd;
          cmd_o.reply = 1'b1;
        end
        S_LOCAL: begin
          cmd_o.emit = 1'b1; cmd_o.kind = K_LOCAL; cmd_o.dsel = 2'd3;
          cmd_o.perm = PermNone;
        end
        S_WB: cmd_o.wr_mem = 1'b1;
        S_DONE: begin
          cmd_o.emit = 1'b1; cmd_o.kind = K_DONE; cmd_o.status = st_q;
          cmd_o.last = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; st_q <= ST_OK;
    end else if (go) begin
      state_q <= S_DIV; st_q <= ST_OK;
    end else if (!stat_i.out_busy) begin
      unique case (state_q)
        S_IDLE: ;
        S_DIV: if (stat_i.div_done) state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.wrong_home) begin st_q <= ST_WRONG; state_q <= S_DONE; end
          else if (stat_i.req_bad) begin st_q <= ST_INCONSIS; state_q <= S_DONE; end
          else state_q <= S_RD;
        end
        S_RD: state_q <= S_CAP;
        S_CAP: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (stat_i.mod_bad) begin st_q <= ST_INCONSIS; state_q <= S_DONE; end
          else if (!stat_i.func && !stat_i.modified) begin
            if (stat_i.req_local) begin st_q <= ST_INCONSIS; state_q <= S_DONE; end
            else state_q <= S_WB;
          end else if (!stat_i.func) begin
            state_q <= stat_i.req_local ? S_WB : S_SEND2;
          end else if (!stat_i.modified) begin
            if (!stat_i.req_local && stat_i.local_not_rd) begin
              st_q <= ST_INCONSIS; state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end else state_q <= S_GRANT;
        end
        S_SCAN: if (stat_i.scan_end) state_q <= S_GRANT;
        S_GRANT: state_q <= stat_i.req_local ? S_WB : S_LOCAL;
        S_SEND2: state_q <= S_WB;
        S_LOCAL: state_q <= S_WB;
        S_WB: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/page_directory_coherence_engine.sv
`default_nettype none
// Steps from request acceptance to the completion on the output: division,
//   check, directory read and capture, a scan over up to MaxOwners nodes,
//   grant, local update, write-back, completion.
// Requests: one at a time, up to 9 messages per request; output stalls
//   hold the engine.
// Reset: asynchronous, active low; node_id 0, owner_count 1, and every
//   directory entry reads readable, no modifier, all nodes reading.
module page_directory_coherence_engine import pdce_pkg::*; #(
  parameter int MaxOwners  = MaxOwnersDef,
  parameter int LocalPages = LocalPagesDef,
  parameter int TotalPages = TotalPagesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [2:0]  requester_i,
  input  wire logic [10:0] page_i,
  input  wire logic [7:0]  tag_i,
  input  wire logic        tag_valid_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  msg_kind_o,
  output logic      [2:0]  dest_o,
  output logic      [10:0] page_out_o,
  output logic      [1:0]  perm_o,
  output logic             is_reply_o,
  output logic      [7:0]  reply_tag_o,
  output logic      [1:0]  status_o,
  output logic             last_o
);
  logic [2:0] node_id_q;
  logic [3:0] owner_cnt_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0; owner_cnt_q <= 4'd1;
    end else if (wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == RegNodeId) node_id_q <= pwdata[2:0];
      else owner_cnt_q <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2] == RegOwnCnt) prdata = {28'd0, owner_cnt_q};
      else prdata = {29'd0, node_id_q};
    end
  end

  cmd_t  cmd;
  stat_t stat;

  pdce_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o), .stat_i(stat), .cmd_o(cmd)
  );

  pdce_datapath #(.MaxOwners(MaxOwners), .LocalPages(LocalPages),
                  .TotalPages(TotalPages)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .stat_o(stat),
    .node_id_i(node_id_q), .owner_count_i(owner_cnt_q),
    .func_i(func_i), .requester_i(requester_i), .page_i(page_i),
    .tag_i(tag_i), .tag_valid_i(tag_valid_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .msg_kind_o(msg_kind_o), .dest_o(dest_o), .page_out_o(page_out_o),
    .perm_o(perm_o), .is_reply_o(is_reply_o), .reply_tag_o(reply_tag_o),
    .status_o(status_o), .last_o(last_o)
  );
endmodule
`default_nettype wire

FILE: verif/page_directory_coherence_engine_tb.sv
module page_directory_coherence_engine_tb;
  import pdce_pkg::*;

  // One message of a request's run, at the block's output widths.
  typedef struct {
    kind_e      kind;
    logic [2:0] dest;
    logic [10:0] pg;
    logic [1:0] perm;
    logic       rep;
    logic [7:0] tag;
    status_e    st;
    logic       last;
  } msg_t;

  // One line of the directed table: either a register setting or a request.
  // chk marks rows whose completion status is typed in by hand.
  typedef struct {
    bit         is_cfg;
    logic [2:0] node;
    logic [3:0] cnt;
    logic       func;
    logic [2:0] req;
    logic [10:0] pg;
    logic [7:0] tag;
    logic       tv;
    bit         chk;
    status_e    exp_st;
  } row_t;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [2:0] requester_i = '0;
  logic [10:0] page_i = '0;
  logic [7:0] tag_i = '0;
  logic tag_valid_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] msg_kind_o, dest_o;
  logic [10:0] page_out_o;
  logic [1:0] perm_o, status_o;
  logic is_reply_o, last_o;
  logic [7:0] reply_tag_o;

  page_directory_coherence_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the directory and the two registers.
  logic       dir_mod [256];
  logic [2:0] dir_owner [256];
  nstate_e    dir_node [256][8];
  logic [2:0] node_id_q;
  logic [3:0] owner_cnt_q;

  msg_t pending_msgs[$];
  int   errors = 0;
  int   cycles = 0;
  int   tx_idle_pct = 0;   // sender gap chance per request, percent
  int   rx_idle_pct = 0;   // receiver stall chance per cycle, percent

  function automatic void push_msg(kind_e k, logic [2:0] d, logic [10:0] p,
                                   logic [1:0] pm, logic r, logic [7:0] t,
                                   status_e s, logic l);
    msg_t m;
    m.kind = k; m.dest = d; m.pg = p; m.perm = pm;
    m.rep = r; m.tag = t; m.st = s; m.last = l;
    pending_msgs.push_back(m);
  endfunction

  // Works out the message run of one accepted request, updates the
  // directory copy, and returns the completion status.
  function automatic status_e predict_run(logic f, logic [2:0] req,
                                          logic [10:0] pg, logic [7:0] tag,
                                          logic tv);
    int cnt;
    int idx;
    logic [2:0] mo;
    logic [2:0] nd;
    bit had_read;
    status_e st;
    st  = ST_OK;
    nd  = node_id_q;
    cnt = (owner_cnt_q == 0) ? 1 : ((owner_cnt_q > 8) ? 8 : owner_cnt_q);
    idx = (pg / cnt) % 256;
    mo  = dir_owner[idx];
    if ((pg % cnt) != nd) st = ST_WRONG;
    else if (req >= cnt || (req != nd && !tv)) st = ST_INCONSIS;
    else if (dir_mod[idx] && (mo >= cnt || mo == req)) st = ST_INCONSIS;
    else if (f == 1'b0) begin
      if (!dir_mod[idx]) begin
        if (req == nd) st = ST_INCONSIS;
        else begin
          push_msg(K_SEND, req, pg, PermRd, 1'b1, tag, ST_OK, 1'b0);
          dir_node[idx][req] = NS_READING;
        end
      end else begin
        if (mo != nd) begin
          push_msg(K_FETCH, mo, pg, PermRd, 1'b0, '0, ST_OK, 1'b0);
          dir_node[idx][nd] = NS_READING;
        end
        dir_node[idx][mo] = NS_READING;
        dir_owner[idx] = '0;
        dir_mod[idx] = 1'b0;
        if (req != nd) begin
          push_msg(K_SEND, req, pg, PermRd, 1'b1, tag, ST_OK, 1'b0);
          dir_node[idx][req] = NS_READING;
        end
      end
    end else if (!dir_mod[idx]) begin
      if (req != nd && dir_node[idx][nd] != NS_READING) st = ST_INCONSIS;
      else begin
        had_read = (dir_node[idx][req] == NS_READING);
        // invalidate every other reader except requester and home
        for (int i = 0; i < cnt; i++) begin
          if (i != req && i != nd && dir_node[idx][i] == NS_READING) begin
            push_msg(K_SETPERM, 3'(i), pg, PermNone, 1'b0, '0, ST_OK, 1'b0);
            dir_node[idx][i] = NS_INVALID;
          end
        end
        dir_node[idx][req] = NS_MODIFYING;
        dir_owner[idx] = req;
        dir_mod[idx] = 1'b1;
        if (req == nd) push_msg(K_LOCAL, nd, pg, PermRw, 1'b0, '0, ST_OK, 1'b0);
        else begin
          push_msg(had_read ? K_SETPERM : K_SEND, req, pg, PermRw, 1'b1, tag,
                   ST_OK, 1'b0);
          push_msg(K_LOCAL, nd, pg, PermNone, 1'b0, '0, ST_OK, 1'b0);
          dir_node[idx][nd] = NS_INVALID;
        end
      end
    end else begin
      if (mo != nd) push_msg(K_FETCH, mo, pg, PermNone, 1'b0, '0, ST_OK, 1'b0);
      dir_node[idx][mo] = NS_INVALID;
      dir_node[idx][req] = NS_MODIFYING;
      dir_owner[idx] = req;
      if (req == nd) push_msg(K_LOCAL, nd, pg, PermRw, 1'b0, '0, ST_OK, 1'b0);
      else begin
        push_msg(K_SEND, req, pg, PermRw, 1'b1, tag, ST_OK, 1'b0);
        push_msg(K_LOCAL, nd, pg, PermNone, 1'b0, '0, ST_OK, 1'b0);
      end
    end
    // every run closes with the completion
    push_msg(K_DONE, req, pg, PermNone, 1'b0, '0, st, 1'b1);
    return st;
  endfunction

  // Drives one request; returns once the block has taken it.
  task automatic send_request(logic f, logic [2:0] r, logic [10:0] p,
                              logic [7:0] t, logic v, output status_e st);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    requester_i <= r;
    page_i      <= p;
    tag_i       <= t;
    tag_valid_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    st = predict_run(f, r, p, t, v);
  endtask

  // Drops valid and waits until every predicted message has arrived.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write: setup then access; lands at the access edge.
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) node_id_q = data[2:0];
    else owner_cnt_q = data[3:0];
  endtask

  task automatic set_config(logic [2:0] nd, logic [3:0] cnt);
    wait_idle();
    reg_write(3'(4 * RegNodeId), 32'(nd));
    reg_write(3'(4 * RegOwnCnt), 32'(cnt));
  endtask

  function automatic row_t cfg_row(logic [2:0] nd, logic [3:0] cnt);
    row_t r;
    r.is_cfg = 1'b1; r.node = nd; r.cnt = cnt;
    r.chk = 1'b0; r.exp_st = ST_OK;
    return r;
  endfunction

  function automatic row_t req_row(logic f, logic [2:0] rq, logic [10:0] p,
                                   logic [7:0] t, logic v, bit c, status_e s);
    row_t r;
    r.is_cfg = 1'b0; r.node = '0; r.cnt = '0;
    r.func = f; r.req = rq; r.pg = p; r.tag = t; r.tv = v;
    r.chk = c; r.exp_st = s;
    return r;
  endfunction

  // Output side: random stall, and each accepted message checked in order.
  always @(posedge clk_i) begin
    msg_t m;
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_msgs.size() == 0) begin
        $error("message with nothing pending: kind %0d dest %0d page %0d",
               msg_kind_o, dest_o, page_out_o);
        errors++;
      end else begin
        m = pending_msgs.pop_front();
        if (msg_kind_o != m.kind) begin
          $error("msg_kind: exp %0d got %0d", m.kind, msg_kind_o); errors++;
        end
        if (dest_o != m.dest) begin
          $error("dest: exp %0d got %0d", m.dest, dest_o); errors++;
        end
        if (page_out_o != m.pg) begin
          $error("page_out: exp %0d got %0d", m.pg, page_out_o); errors++;
        end
        if (perm_o != m.perm) begin
          $error("perm: exp %0d got %0d", m.perm, perm_o); errors++;
        end
        if (is_reply_o != m.rep) begin
          $error("is_reply: exp %0d got %0d", m.rep, is_reply_o); errors++;
        end
        if (reply_tag_o != m.tag) begin
          $error("reply_tag: exp %0d got %0d", m.tag, reply_tag_o); errors++;
        end
        if (status_o != m.st) begin
          $error("status: exp %0d got %0d", m.st, status_o); errors++;
        end
        if (last_o != m.last) begin
          $error("last: exp %0d got %0d", m.last, last_o); errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t    dir_rows[$];
    status_e st;
    int      cnt_eff;
    logic [2:0] rq;
    logic [10:0] pg;
    logic [2:0] phase_node [7];
    logic [3:0] phase_cnt [7];

    node_id_q = '0;
    owner_cnt_q = 4'd1;
    for (int i = 0; i < 256; i++) begin
      dir_mod[i] = 1'b0;
      dir_owner[i] = '0;
      for (int j = 0; j < 8; j++) dir_node[i][j] = NS_READING;
    end

    // Directed table. Reset settings first: node 0 is home of everything.
    dir_rows.push_back(req_row(0, 0, 0, 0, 0, 1, ST_INCONSIS));   // local read, clean
    dir_rows.push_back(req_row(1, 0, 2047, 8'hFF, 1, 1, ST_OK)); // local write grant
    dir_rows.push_back(req_row(0, 1, 300, 8'h11, 1, 1, ST_INCONSIS)); // requester too high
    dir_rows.push_back(req_row(0, 0, 2047, 8'h00, 0, 1, ST_INCONSIS)); // request by modifier
    dir_rows.push_back(req_row(1, 0, 44, 0, 0, 0, ST_OK));       // aliases page 300 after the wrap
    dir_rows.push_back(cfg_row(3'd1, 4'd4));
    dir_rows.push_back(req_row(0, 2, 0, 8'h5A, 1, 1, ST_WRONG));  // not home
    dir_rows.push_back(req_row(0, 2, 1, 8'h33, 0, 1, ST_INCONSIS)); // remote, no tag
    dir_rows.push_back(req_row(0, 2, 1, 8'hAA, 1, 1, ST_OK));
    dir_rows.push_back(req_row(1, 3, 1, 8'h55, 1, 0, ST_OK));     // invalidates readers
    dir_rows.push_back(req_row(1, 3, 1, 8'h01, 1, 1, ST_INCONSIS)); // modifier again
    dir_rows.push_back(req_row(0, 0, 1, 8'h80, 1, 0, ST_OK));     // fetch from 3
    dir_rows.push_back(req_row(1, 1, 1, 8'h00, 0, 0, ST_OK));     // local write
    dir_rows.push_back(req_row(0, 2, 1, 8'h7F, 1, 0, ST_OK));     // home was modifier
    dir_rows.push_back(req_row(1, 2, 5, 8'hC3, 1, 0, ST_OK));
    dir_rows.push_back(req_row(1, 0, 5, 8'h3C, 1, 0, ST_OK));     // write of modified
    dir_rows.push_back(req_row(0, 1, 5, 8'h00, 0, 0, ST_OK));     // local read, modified
    dir_rows.push_back(req_row(1, 3, 9, 8'h99, 1, 0, ST_OK));
    dir_rows.push_back(cfg_row(3'd7, 4'd8));
    dir_rows.push_back(req_row(1, 6, 15, 8'h42, 1, 0, ST_OK));    // modifier 6
    dir_rows.push_back(req_row(0, 7, 2047, 8'hE7, 1, 0, ST_OK));
    dir_rows.push_back(cfg_row(3'd3, 4'd4));
    dir_rows.push_back(req_row(0, 2, 7, 8'h24, 1, 1, ST_INCONSIS)); // stale modifier
    dir_rows.push_back(cfg_row(3'd0, 4'd0));
    dir_rows.push_back(req_row(1, 0, 1000, 8'h10, 1, 0, ST_OK));  // count 0 acts as 1

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_config(dir_rows[i].node, dir_rows[i].cnt);
      else begin
        send_request(dir_rows[i].func, dir_rows[i].req, dir_rows[i].pg,
                     dir_rows[i].tag, dir_rows[i].tv, st);
        if (dir_rows[i].chk && st != dir_rows[i].exp_st) begin
          $error("status: exp %0d got %0d (directed row %0d)",
                 dir_rows[i].exp_st, st, i);
          errors++;
        end
      end
    end

    // Random part: one setting and one idling pattern per phase.
    phase_node = '{3'd0, 3'd7, 3'd2, 3'd5, 3'd1, 3'd0, 3'd3};
    phase_cnt  = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd2, 4'd0, 4'd6};
    for (int ph = 0; ph < 7; ph++) begin
      set_config(phase_node[ph], phase_cnt[ph]);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 50; end
        default: begin tx_idle_pct = 14; rx_idle_pct = 14; end
      endcase
      cnt_eff = (owner_cnt_q == 0) ? 1 : ((owner_cnt_q > 8) ? 8 : owner_cnt_q);
      for (int n = 0; n < 50; n++) begin
        // mostly legal requesters and home pages on a few hot entries
        rq = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, cnt_eff - 1))
                                          : 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 10) pg = 11'($urandom_range(0, 2047));
        else if ($urandom_range(0, 99) < 80)
          pg = 11'(node_id_q + cnt_eff * $urandom_range(0, 7));
        else pg = 11'(node_id_q + cnt_eff * $urandom_range(0, 2047 / cnt_eff));
        send_request($urandom_range(0, 1), rq, pg, 8'($urandom_range(0, 255)),
                     $urandom_range(0, 99) < 90, st);
        // hold off once per phase until the block has fully drained
        if (n == 25) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending_msgs.size() != 0) @(posedge clk_i);
        end
      end
    end

    wait_idle();
    if (errors == 0 && pending_msgs.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pdce_pkg.sv
rtl/pdce_ram.sv
rtl/pdce_datapath.sv
rtl/pdce_ctrl.sv
rtl/page_directory_coherence_engine.sv
verif/page_directory_coherence_engine_tb.sv
